// ===== hw/rtl/ctlex_pkg.sv =====
`timescale 1ns / 1ps

package ctlex_pkg;

   localparam int unsigned MaxTokensDefault = 50;
   localparam int unsigned TokenCountW      = 7;
   localparam int unsigned ByteW            = 8;
   localparam int unsigned ValueW           = 32;
   localparam int unsigned KindW            = 4;
   localparam int unsigned IdentLenW        = 3;
   localparam int unsigned KeywordCount     = 3;

   // result queue behind the scanner
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QPtrW      = $clog2(QueueDepth);
   localparam int unsigned QCountW    = $clog2(QueueDepth + 1);

   localparam logic [ByteW-1:0] CharLParen = 8'h28;
   localparam logic [ByteW-1:0] CharRParen = 8'h29;
   localparam logic [ByteW-1:0] CharLBrace = 8'h7B;
   localparam logic [ByteW-1:0] CharRBrace = 8'h7D;
   localparam logic [ByteW-1:0] CharSemi   = 8'h3B;
   localparam logic [ByteW-1:0] CharZero   = 8'h30;
   localparam logic [ByteW-1:0] CharNine   = 8'h39;
   localparam logic [ByteW-1:0] CharLowA   = 8'h61;
   localparam logic [ByteW-1:0] CharLowZ   = 8'h7A;
   localparam logic [ByteW-1:0] CharUpA    = 8'h41;
   localparam logic [ByteW-1:0] CharUpZ    = 8'h5A;
   localparam logic [ByteW-1:0] CharNul    = 8'h00;

   typedef enum logic [KindW-1:0] {
      KIND_INT    = 4'd0,
      KIND_MAIN   = 4'd1,
      KIND_LPAREN = 4'd2,
      KIND_RPAREN = 4'd3,
      KIND_LBRACE = 4'd4,
      KIND_RBRACE = 4'd5,
      KIND_RETURN = 4'd6,
      KIND_NUMBER = 4'd7,
      KIND_SEMI   = 4'd8,
      KIND_END    = 4'd9,
      KIND_IDENT  = 4'd10
   } token_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_NUM  = 3'b010,
      MODE_ID   = 3'b100
   } run_mode_type;

   typedef enum logic [1:0] {
      KW_INT    = 2'd0,
      KW_MAIN   = 2'd1,
      KW_RETURN = 2'd2
   } keyword_type;

   typedef struct packed {
      run_mode_type              mode;
      logic [ValueW-1:0]         accum;
      logic [IdentLenW-1:0]      ident_len;
      logic [KeywordCount-1:0]   kw_match;
      logic [TokenCountW-1:0]    given;
   } lex_state_type;

   localparam lex_state_type LexStateReset = '{
      mode:      MODE_IDLE,
      accum:     '0,
      ident_len: '0,
      kw_match:  '1,
      given:     '0
   };

   typedef struct packed {
      logic [KindW-1:0]  kind;
      logic [ValueW-1:0] value;
      logic              last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } scan_result_type;

   function automatic logic [IdentLenW-1:0] kw_len(input keyword_type k);
      logic [IdentLenW-1:0] len;
      case (k)
         KW_INT:    len = 3'd3;
         KW_MAIN:   len = 3'd4;
         KW_RETURN: len = 3'd6;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [ByteW-1:0] kw_char(input keyword_type k,
                                                input logic [IdentLenW-1:0] p);
      logic [ByteW-1:0] ch;
      ch = CharNul;
      case (k)
         KW_INT: begin
            case (p)
               3'd0:    ch = 8'h69;
               3'd1:    ch = 8'h6E;
               3'd2:    ch = 8'h74;
               default: ch = CharNul;
            endcase
         end
         KW_MAIN: begin
            case (p)
               3'd0:    ch = 8'h6D;
               3'd1:    ch = 8'h61;
               3'd2:    ch = 8'h69;
               3'd3:    ch = 8'h6E;
               default: ch = CharNul;
            endcase
         end
         KW_RETURN: begin
            case (p)
               3'd0:    ch = 8'h72;
               3'd1:    ch = 8'h65;
               3'd2:    ch = 8'h74;
               3'd3:    ch = 8'h75;
               3'd4:    ch = 8'h72;
               3'd5:    ch = 8'h6E;
               default: ch = CharNul;
            endcase
         end
         default: ch = CharNul;
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/ctlex_if.sv =====
`timescale 1ns / 1ps

interface ctlex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ctlex_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [31:0] token_value;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_value,
                   output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input token_value,
                   input last_of_run, output ready);
endinterface

// ===== hw/rtl/c_subset_token_lexer.sv =====
`timescale 1ns / 1ps
// Tokens are registered in the result queue and shown on rsp from there.
// Throughput: one byte per cycle while req is ready; a byte that gives two tokens
// pushes both into a four-entry result queue (req stalls when under two free).
// rsp drains at most one token per cycle.
// Reset (synchronous, active high) empties the queue and returns the scanner to idle.
module c_subset_token_lexer #(
   parameter int unsigned MAX_TOKENS = ctlex_pkg::MaxTokensDefault
) (
   input  logic             clock,
   input  logic             reset,
   ctlex_req_if.sink        req_chan,
   ctlex_rsp_if.source      rsp_chan
);
   import ctlex_pkg::*;

   localparam logic [TokenCountW-1:0] TokenLimit = TokenCountW'(MAX_TOKENS);

   lex_state_type   lex_state_ff, lex_state_in, scan_state;
   scan_result_type scan_res;

   token_type          q_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCountW-1:0] q_count_ff, q_count_in;
   logic               accept_req, pop_rsp;
   logic [1:0]         push_count;

   ctlex_scan #(.MAX_TOKENS(MAX_TOKENS)) u_scan (
      .cur_state   (lex_state_ff),
      .text_byte   (req_chan.text_byte),
      .end_of_text (req_chan.end_of_text),
      .nxt_state   (scan_state),
      .result      (scan_res)
   );

   // hold off the request unless at least two result slots are free
   assign req_chan.ready = (q_count_ff <= QCountW'(QueueDepth - 2));
   assign accept_req     = req_chan.valid && req_chan.ready;
   assign pop_rsp        = rsp_chan.valid && rsp_chan.ready;
   assign push_count     = accept_req ? scan_res.count : 2'd0;

   assign lex_state_in = accept_req ? scan_state : lex_state_ff;
   assign wr_ptr_in    = wr_ptr_ff + QPtrW'(push_count);
   assign rd_ptr_in    = rd_ptr_ff + QPtrW'(pop_rsp);
   assign q_count_in   = q_count_ff + QCountW'(push_count) - QCountW'(pop_rsp);

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_state_ff <= LexStateReset;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         q_count_ff   <= '0;
      end else begin
         lex_state_ff <= lex_state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         q_count_ff   <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0)
         q_ff[wr_ptr_ff] <= scan_res.tok0;
      if (push_count == 2'd2)
         q_ff[QPtrW'(wr_ptr_ff + 1'b1)] <= scan_res.tok1;
   end

   assign rsp_chan.valid       = (q_count_ff != '0);
   assign rsp_chan.token_kind  = q_ff[rd_ptr_ff].kind;
   assign rsp_chan.token_value = q_ff[rd_ptr_ff].value;
   assign rsp_chan.last_of_run = q_ff[rd_ptr_ff].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QCountW'(QueueDepth))
      else $error("result queue overfilled");

   a_limit_held: assert property (@(posedge clock) disable iff (reset)
      lex_state_ff.given <= TokenLimit)
      else $error("token count passed the limit");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept_req && (req_chan.end_of_text || req_chan.text_byte == CharNul))
      |=> (lex_state_ff.mode == MODE_IDLE && lex_state_ff.given == '0
           && lex_state_ff.accum == '0))
      else $error("scanner not idle after end of text");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.token_kind == KIND_END) |-> rsp_chan.last_of_run)
      else $error("end token not marked last");

endmodule

// ===== hw/rtl/ctlex_scan.sv =====
`timescale 1ns / 1ps

module ctlex_scan #(
   parameter int unsigned MAX_TOKENS = ctlex_pkg::MaxTokensDefault
) (
   input  ctlex_pkg::lex_state_type   cur_state,
   input  logic [7:0]                 text_byte,
   input  logic                       end_of_text,
   output ctlex_pkg::lex_state_type   nxt_state,
   output ctlex_pkg::scan_result_type result
);
   import ctlex_pkg::*;

   localparam logic [TokenCountW-1:0] TokenLimit = TokenCountW'(MAX_TOKENS);

   function automatic logic [TokenCountW-1:0] sat_inc(input logic [TokenCountW-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [KeywordCount-1:0] kw_next(
      input logic [KeywordCount-1:0] km,
      input logic [IdentLenW-1:0]    p,
      input logic [ByteW-1:0]        ch);
      logic [KeywordCount-1:0] res;
      res = km;
      for (int i = 0; i < KeywordCount; i++) begin
         if (p >= kw_len(keyword_type'(i)) || kw_char(keyword_type'(i), p) != ch)
            res[i] = 1'b0;
      end
      return res;
   endfunction

   logic                   is_end, is_digit, is_lower, is_upper;
   logic                   mode_num, mode_id, close_num, close_id, closing;
   logic [TokenCountW-1:0] given_mid;
   logic [KindW-1:0]       ident_kind;
   token_type              tok_close, tok_second;
   logic                   second_valid;
   logic [ValueW-1:0]      digit_val;

   assign is_end   = end_of_text || (text_byte == CharNul);
   assign is_digit = text_byte inside {[CharZero:CharNine]};
   assign is_lower = text_byte inside {[CharLowA:CharLowZ]};
   assign is_upper = text_byte inside {[CharUpA:CharUpZ]};
   assign digit_val = ValueW'(text_byte - CharZero);

   assign mode_num  = (cur_state.mode == MODE_NUM);
   assign mode_id   = (cur_state.mode == MODE_ID);
   assign close_num = mode_num && (is_end || !is_digit);
   assign close_id  = mode_id && (is_end || !(is_lower || is_upper || is_digit));
   assign closing   = close_num || close_id;
   assign given_mid = closing ? sat_inc(cur_state.given) : cur_state.given;

   always_comb begin
      if (cur_state.ident_len == 3'd3 && cur_state.kw_match[KW_INT])
         ident_kind = KIND_INT;
      else if (cur_state.ident_len == 3'd4 && cur_state.kw_match[KW_MAIN])
         ident_kind = KIND_MAIN;
      else if (cur_state.ident_len == 3'd6 && cur_state.kw_match[KW_RETURN])
         ident_kind = KIND_RETURN;
      else
         ident_kind = KIND_IDENT;
   end

   always_comb begin
      tok_close.kind  = close_num ? KIND_NUMBER : ident_kind;
      tok_close.value = close_num ? cur_state.accum : '0;
      tok_close.last  = 1'b0;
   end

   always_comb begin
      nxt_state         = cur_state;
      nxt_state.given   = given_mid;
      second_valid      = 1'b0;
      tok_second.kind   = KIND_END;
      tok_second.value  = '0;
      tok_second.last   = 1'b1;

      // a run that survives this byte stays open, anything else drops to idle
      if (mode_num && !closing)
         nxt_state.mode = MODE_NUM;
      else if (mode_id && !closing)
         nxt_state.mode = MODE_ID;
      else
         nxt_state.mode = MODE_IDLE;
      if (close_num)
         nxt_state.accum = '0;
      if (close_id) begin
         nxt_state.ident_len = '0;
         nxt_state.kw_match  = '1;
      end

      if (is_end) begin
         nxt_state    = LexStateReset;
         second_valid = 1'b1;
      end else if (mode_num && !closing) begin
         nxt_state.accum = (cur_state.accum << 3) + (cur_state.accum << 1) + digit_val;
      end else if (mode_id && !closing) begin
         nxt_state.kw_match  = kw_next(cur_state.kw_match, cur_state.ident_len, text_byte);
         nxt_state.ident_len = (cur_state.ident_len == '1) ? cur_state.ident_len
                                                            : cur_state.ident_len + 1'b1;
      end else if (given_mid < TokenLimit) begin
         case (text_byte)
            CharLParen: begin second_valid = 1'b1; tok_second.kind = KIND_LPAREN; end
            CharRParen: begin second_valid = 1'b1; tok_second.kind = KIND_RPAREN; end
            CharLBrace: begin second_valid = 1'b1; tok_second.kind = KIND_LBRACE; end
            CharRBrace: begin second_valid = 1'b1; tok_second.kind = KIND_RBRACE; end
            CharSemi:   begin second_valid = 1'b1; tok_second.kind = KIND_SEMI;   end
            default: begin
               if (is_digit) begin
                  nxt_state.mode  = MODE_NUM;
                  nxt_state.accum = digit_val;
               end else if (is_lower) begin
                  nxt_state.mode      = MODE_ID;
                  nxt_state.ident_len = 3'd1;
                  nxt_state.kw_match  = kw_next('1, '0, text_byte);
               end
            end
         endcase
         if (second_valid)
            nxt_state.given = sat_inc(given_mid);
      end
   end

   always_comb begin
      result.count = {1'b0, closing} + {1'b0, second_valid};
      result.tok1  = tok_second;
      if (closing) begin
         result.tok0      = tok_close;
         result.tok0.last = !second_valid;
      end else begin
         result.tok0 = tok_second;
      end
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ctlex_pkg::*;

   localparam int unsigned MaxTokens   = MaxTokensDefault;
   localparam int unsigned StallLimit  = 2000;
   localparam int unsigned PhaseItems  = 300;
   localparam logic [ByteW-1:0] CharSpace   = 8'h20;
   localparam logic [ByteW-1:0] CharTab     = 8'h09;
   localparam logic [ByteW-1:0] CharNewline = 8'h0A;
   localparam logic [ByteW-1:0] CharReturn  = 8'h0D;

   typedef struct packed {
      token_kind_type    kind;
      logic [ValueW-1:0] value;
      logic              last;
   } lex_token_type;

   logic clock;
   logic reset;

   ctlex_req_if req_chan();
   ctlex_rsp_if rsp_chan();

   c_subset_token_lexer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // scanner mirror
   run_mode_type           scan_mode   = MODE_IDLE;
   logic [ValueW-1:0]      digit_value = '0;
   logic [IdentLenW-1:0]   word_len    = '0;
   logic [KeywordCount-1:0] kw_hits    = '1;
   logic [TokenCountW-1:0] emitted_tokens = '0;

   lex_token_type expected_tokens [$];
   int unsigned error_count     = 0;
   int unsigned lexed_items     = 0;
   int unsigned idle_cycles     = 0;
   int unsigned send_idle_pct   = 0;
   int unsigned ready_stall_pct = 0;
   int unsigned send_burst      = 0;
   int unsigned ready_burst     = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic string keyword_spelling(input int unsigned k);
      case (k)
         0:       return "int";
         1:       return "main";
         default: return "return";
      endcase
   endfunction

   function automatic logic is_digit(input logic [ByteW-1:0] c);
      return c >= CharZero && c <= CharNine;
   endfunction

   function automatic logic is_lower(input logic [ByteW-1:0] c);
      return c >= CharLowA && c <= CharLowZ;
   endfunction

   function automatic logic is_upper(input logic [ByteW-1:0] c);
      return c >= CharUpA && c <= CharUpZ;
   endfunction

   function automatic token_kind_type word_kind();
      if (word_len == 3'd3 && kw_hits[0]) return KIND_INT;
      if (word_len == 3'd4 && kw_hits[1]) return KIND_MAIN;
      if (word_len == 3'd6 && kw_hits[2]) return KIND_RETURN;
      return KIND_IDENT;
   endfunction

   task automatic bump_emitted();
      if (emitted_tokens != '1) emitted_tokens = emitted_tokens + 1'b1;
   endtask

   task automatic add_letter(input logic [ByteW-1:0] c);
      string spell;
      for (int k = 0; k < KeywordCount; k++) begin
         spell = keyword_spelling(k);
         if (word_len >= spell.len() || spell[word_len] != c) kw_hits[k] = 1'b0;
      end
      if (word_len != 3'd7) word_len = word_len + 1'b1;
   endtask

   task automatic clear_scan();
      scan_mode      = MODE_IDLE;
      digit_value    = '0;
      word_len       = '0;
      kw_hits        = '1;
      emitted_tokens = '0;
   endtask

   // Work out the tokens one request gives and queue them.
   task automatic lex_byte(input logic [ByteW-1:0] c, input logic eot);
      lex_token_type  toks [$];
      logic           at_end;
      logic           is_punct;
      token_kind_type punct_kind;
      at_end     = eot || (c == CharNul);
      is_punct   = 1'b1;
      punct_kind = KIND_END;

      if (scan_mode == MODE_NUM && (at_end || !is_digit(c))) begin
         toks.push_back(lex_token_type'{kind: KIND_NUMBER, value: digit_value, last: 1'b0});
         bump_emitted();
         scan_mode   = MODE_IDLE;
         digit_value = '0;
      end else if (scan_mode == MODE_ID &&
                   (at_end || !(is_lower(c) || is_upper(c) || is_digit(c)))) begin
         toks.push_back(lex_token_type'{kind: word_kind(), value: '0, last: 1'b0});
         bump_emitted();
         scan_mode = MODE_IDLE;
         word_len  = '0;
         kw_hits   = '1;
      end

      if (at_end) begin
         toks.push_back(lex_token_type'{kind: KIND_END, value: '0, last: 1'b0});
         clear_scan();
      end else if (scan_mode == MODE_NUM) begin
         digit_value = digit_value * 10 + ValueW'(c - CharZero);
      end else if (scan_mode == MODE_ID) begin
         add_letter(c);
      end else if (emitted_tokens < MaxTokens) begin
         case (c)
            CharLParen: punct_kind = KIND_LPAREN;
            CharRParen: punct_kind = KIND_RPAREN;
            CharLBrace: punct_kind = KIND_LBRACE;
            CharRBrace: punct_kind = KIND_RBRACE;
            CharSemi:   punct_kind = KIND_SEMI;
            default:    is_punct   = 1'b0;
         endcase
         if (is_punct) begin
            toks.push_back(lex_token_type'{kind: punct_kind, value: '0, last: 1'b0});
            bump_emitted();
         end else if (is_digit(c)) begin
            scan_mode   = MODE_NUM;
            digit_value = ValueW'(c - CharZero);
         end else if (is_lower(c)) begin
            scan_mode = MODE_ID;
            word_len  = '0;
            kw_hits   = '1;
            add_letter(c);
         end
      end

      if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
      foreach (toks[i]) expected_tokens.push_back(toks[i]);
      lexed_items++;
   endtask

   task automatic report_mismatch(input string what, input logic [ValueW-1:0] got,
                                  input logic [ValueW-1:0] want);
      $display("tb: mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   always @(posedge clock) begin : check_tokens
      lex_token_type want;
      if (!reset) begin
         // check before predicting: a token never comes in the cycle its byte is taken
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch("unexpected token", ValueW'(rsp_chan.token_kind), '0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_chan.token_kind !== want.kind)
                  report_mismatch("token_kind", ValueW'(rsp_chan.token_kind),
                                  ValueW'(want.kind));
               if (rsp_chan.token_value !== want.value)
                  report_mismatch("token_value", rsp_chan.token_value, want.value);
               if (rsp_chan.last_of_run !== want.last)
                  report_mismatch("last_of_run", ValueW'(rsp_chan.last_of_run),
                                  ValueW'(want.last));
            end
         end
         if (req_chan.valid && req_chan.ready)
            lex_byte(req_chan.text_byte, req_chan.end_of_text);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stall the token side at random, with bursts of full rate.
   always @(posedge clock) begin
      if (ready_burst > 0) begin
         ready_burst    <= ready_burst - 1;
         rsp_chan.ready <= 1'b1;
      end else if ($urandom_range(63) == 0) begin
         ready_burst    <= $urandom_range(30, 10);
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= ready_stall_pct);
      end
   end

   task automatic send_byte(input logic [ByteW-1:0] c, input logic eot);
      if (send_idle_pct != 0 && send_burst == 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      if (send_burst > 0) send_burst--;
      else if ($urandom_range(49) == 0) send_burst = $urandom_range(30, 10);
      req_chan.valid       <= 1'b1;
      req_chan.text_byte   <= c;
      req_chan.end_of_text <= eot;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   function automatic logic [ByteW-1:0] random_punct();
      case ($urandom_range(4))
         0:       return CharLParen;
         1:       return CharRParen;
         2:       return CharLBrace;
         3:       return CharRBrace;
         default: return CharSemi;
      endcase
   endfunction

   function automatic logic [ByteW-1:0] random_space();
      case ($urandom_range(3))
         0:       return CharSpace;
         1:       return CharTab;
         2:       return CharNewline;
         default: return CharReturn;
      endcase
   endfunction

   function automatic logic [ByteW-1:0] random_unknown();
      string others;
      others = "!#+-*/=<>,.\"_";
      case ($urandom_range(2))
         0:       return ByteW'($urandom_range(255, 128));
         1:       return ByteW'($urandom_range(CharUpZ, CharUpA));
         default: return others[$urandom_range(others.len() - 1)];
      endcase
   endfunction

   task automatic send_identifier();
      int unsigned tail;
      send_byte(ByteW'($urandom_range(CharLowZ, CharLowA)), 1'b0);
      tail = $urandom_range(8);
      for (int i = 0; i < tail; i++) begin
         case ($urandom_range(2))
            0:       send_byte(ByteW'($urandom_range(CharLowZ, CharLowA)), 1'b0);
            1:       send_byte(ByteW'($urandom_range(CharUpZ, CharUpA)), 1'b0);
            default: send_byte(ByteW'($urandom_range(CharNine, CharZero)), 1'b0);
         endcase
      end
   endtask

   task automatic send_number();
      int unsigned digits;
      if ($urandom_range(9) == 0) begin
         send_text($urandom_range(1) ? "4294967295" : "4294967296");
      end else begin
         digits = ($urandom_range(3) == 0) ? $urandom_range(14, 10) : $urandom_range(6, 1);
         for (int i = 0; i < digits; i++)
            send_byte(ByteW'($urandom_range(CharNine, CharZero)), 1'b0);
      end
   endtask

   // Keyword with one letter short, one extra, or one letter in uppercase.
   task automatic send_near_keyword();
      string       spell;
      int unsigned pos;
      spell = keyword_spelling($urandom_range(2));
      pos   = $urandom_range(spell.len() - 1);
      case ($urandom_range(2))
         0: for (int i = 0; i < spell.len() - 1; i++) send_byte(spell[i], 1'b0);
         1: begin
            send_text(spell);
            send_byte(ByteW'($urandom_range(1) ? $urandom_range(CharLowZ, CharLowA)
                                               : $urandom_range(CharNine, CharZero)), 1'b0);
         end
         default:
            for (int i = 0; i < spell.len(); i++)
               send_byte((i == pos) ? spell[i] - 8'd32 : spell[i], 1'b0);
      endcase
   endtask

   task automatic send_end();
      if ($urandom_range(2) == 0) send_byte(CharNul, 1'b0);
      else send_byte(ByteW'($urandom_range(255)), 1'b1);
   endtask

   task automatic send_program();
      int unsigned pieces;
      int unsigned roll;
      // long programs run past the token limit
      pieces = ($urandom_range(7) == 0) ? $urandom_range(110, 60) : $urandom_range(16, 2);
      for (int i = 0; i < pieces; i++) begin
         roll = $urandom_range(99);
         if (roll < 14) send_text(keyword_spelling($urandom_range(2)));
         else if (roll < 28) send_identifier();
         else if (roll < 42) send_number();
         else if (roll < 50) send_near_keyword();
         else if (roll < 78) send_byte(random_punct(), 1'b0);
         else if (roll < 90) send_byte(random_space(), 1'b0);
         else send_byte(random_unknown(), 1'b0);
         // mostly separate runs; sometimes let them merge
         if (roll < 50 && $urandom_range(9) < 7)
            send_byte($urandom_range(1) ? random_space() : random_punct(), 1'b0);
      end
      send_end();
   endtask

   task automatic send_noise();
      int unsigned count;
      count = $urandom_range(30, 5);
      for (int i = 0; i < count; i++)
         send_byte(ByteW'($urandom_range(255)), $urandom_range(29) == 0);
   endtask

   task automatic test_punct_and_keywords();
      send_text("int{main(9)}");
      send_byte(8'hFF, 1'b0);
      send_text("Z return;");
      // end of text at idle; the byte itself is dropped
      send_byte(CharLParen, 1'b1);
   endtask

   task automatic test_end_cases();
      send_text("ab");
      send_byte(CharNul, 1'b0);
      send_text("7");
      send_byte(8'h80, 1'b1);
   endtask

   task automatic test_random_programs(input int unsigned idle_pct, input int unsigned stall_pct);
      int unsigned start;
      send_idle_pct   = idle_pct;
      ready_stall_pct = stall_pct;
      start           = lexed_items;
      while (lexed_items - start < PhaseItems) begin
         if ($urandom_range(99) < 15) send_noise();
         else send_program();
      end
   endtask

   task automatic finish_run();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   endtask

   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.text_byte   <= CharNul;
      req_chan.end_of_text <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_punct_and_keywords();
      test_end_cases();
      test_random_programs(0, 0);
      test_random_programs(72, 0);
      test_random_programs(0, 72);
      test_random_programs(36, 36);
      finish_run();
   end

endmodule
